// ----- rtl/core/psam_pkg.sv -----
// ----------------------------------------------------------------------------
// psam_pkg
// Shared widths, status codes and register indexes for the particulate
// smoke alarm with window means.
// ----------------------------------------------------------------------------
package psam_pkg;

    localparam int MAX_SAMPLES = 1024;

    localparam int PM_W     = 16;
    localparam int RUN_W    = 16;
    localparam int MEAN_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W    = PM_W + $clog2(MAX_SAMPLES);
    localparam int ITER_W   = $clog2(SUM_W + 1);

    localparam int IN_DATA_W  = 4 * PM_W;
    localparam int IN_USER_W  = 2;
    localparam int OUT_USED_W = 2 + RUN_W + 2 + 1 + 3 * MEAN_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_WARNING = 2'd1,
        STAT_ALERT   = 2'd2,
        STAT_ERROR   = 2'd3
    } status_t;

    localparam logic [CFG_IDX_W-1:0] REG_SMOKE_WARN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMOKE_EXTRA = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PM25_THRESH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PM10_THRESH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HCHO_LIMIT  = 3'd4;

endpackage

// ----- rtl/core/psam_div.sv -----
// ----------------------------------------------------------------------------
// psam_div
// Bit-serial restoring divider: window sum over sample count, one quotient
// bit per cycle, quotient shifted into the vacated dividend bits.
// ----------------------------------------------------------------------------
module psam_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [psam_pkg::SUM_W-1:0]   dividend,
    input  logic [psam_pkg::CNT_W-1:0]   divisor,
    output logic                         done,
    output logic [psam_pkg::MEAN_W-1:0]  quotient
);

    logic [psam_pkg::SUM_W-1:0]  work_reg;
    logic [psam_pkg::SUM_W-1:0]  work_next;
    logic [psam_pkg::CNT_W-1:0]  rem_reg;
    logic [psam_pkg::CNT_W-1:0]  rem_next;
    logic [psam_pkg::CNT_W-1:0]  dvs_reg;
    logic [psam_pkg::ITER_W-1:0] iter_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [psam_pkg::CNT_W:0]    trial;
    logic [psam_pkg::CNT_W:0]    dvs_ext;
    logic [psam_pkg::CNT_W:0]    diff;
    logic                        ge;

    always_comb
    begin
        trial     = {rem_reg, work_reg[psam_pkg::SUM_W-1]};
        dvs_ext   = {1'b0, dvs_reg};
        ge        = (trial >= dvs_ext);
        diff      = trial - dvs_ext;
        rem_next  = ge ? diff[psam_pkg::CNT_W-1:0] : trial[psam_pkg::CNT_W-1:0];
        work_next = {work_reg[psam_pkg::SUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= psam_pkg::ITER_W'(psam_pkg::SUM_W);
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg - 1'b1;
                if (iter_reg == psam_pkg::ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg[psam_pkg::MEAN_W-1:0];

endmodule

// ----- rtl/core/particulate_smoke_alarm_with_mean_core.sv -----
// ----------------------------------------------------------------------------
// particulate_smoke_alarm_with_mean_core
// Smoke run tracking, status classification and windowed PM means.
// ----------------------------------------------------------------------------
// Timing: an accepted input sets pend_reg, then its result is loaded into
//   m_tdata; on window close pend_reg is set only after the 26 divide steps.
// Input: no new item is taken until the previous result is loaded into the
//   output register, nor while the window-closing divides run.
// Stalls: input is held off while a result waits for the output side.
// Reset: async, active low; clears control and window state; config to defaults.
// ----------------------------------------------------------------------------
module particulate_smoke_alarm_with_mean_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // config write port
    input  logic                                 cfg_we,
    input  logic [psam_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [psam_pkg::CFG_W-1:0]           cfg_data,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [psam_pkg::IN_DATA_W-1:0]       s_tdata,  // pm1, pm25, pm10, hcho
    input  logic [psam_pkg::IN_USER_W-1:0]       s_tuser,  // sensor_ok, hcho_present
    input  logic                                 s_tlast,  // window_end
    // output stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // overall_status, smoke_count, smoke_level, hcho_alarm,
    // pm1_mean, pm25_mean, pm10_mean, zero pad
    output logic [psam_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                 m_tuser   // mean_updated
);

    typedef enum logic [1:0] {
        IDLE = 2'b01,
        DIV  = 2'b10
    } state_t;

    localparam int PM_W   = psam_pkg::PM_W;
    localparam int RUN_W  = psam_pkg::RUN_W;
    localparam int SUM_W  = psam_pkg::SUM_W;
    localparam int CNT_W  = psam_pkg::CNT_W;
    localparam int MEAN_W = psam_pkg::MEAN_W;

    state_t state_reg;

    logic [psam_pkg::CFG_W-1:0] warn_reg;
    logic [psam_pkg::CFG_W-1:0] extra_reg;
    logic [psam_pkg::CFG_W-1:0] thr25_reg;
    logic [psam_pkg::CFG_W-1:0] thr10_reg;
    logic [psam_pkg::CFG_W-1:0] hlimit_reg;

    logic [RUN_W-1:0]  run_reg;
    logic [SUM_W-1:0]  sum1_reg;
    logic [SUM_W-1:0]  sum25_reg;
    logic [SUM_W-1:0]  sum10_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [MEAN_W-1:0] avg1_reg;
    logic [MEAN_W-1:0] avg25_reg;
    logic [MEAN_W-1:0] avg10_reg;
    psam_pkg::status_t smoke_reg;
    logic              hcho_reg;
    psam_pkg::status_t status_reg;
    logic              upd_reg;
    logic              pend_reg;

    logic [PM_W-1:0]   pm1;
    logic [PM_W-1:0]   pm25;
    logic [PM_W-1:0]   pm10;
    logic [PM_W-1:0]   hcho;
    logic              sensor_ok;
    logic              hcho_present;
    logic              accept;
    logic              smoky;
    logic              acc_en;
    logic [RUN_W-1:0]  run_next;
    logic [SUM_W-1:0]  sum1_next;
    logic [SUM_W-1:0]  sum25_next;
    logic [SUM_W-1:0]  sum10_next;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  divisor;
    logic [RUN_W:0]    alert_at;
    psam_pkg::status_t status_next;
    psam_pkg::status_t smoke_next;
    logic              hcho_next;
    logic              div_start;
    logic [2:0]        div_done;
    logic [MEAN_W-1:0] q1;
    logic [MEAN_W-1:0] q25;
    logic [MEAN_W-1:0] q10;
    logic              out_load;

    assign pm1          = s_tdata[PM_W-1:0];
    assign pm25         = s_tdata[2*PM_W-1:PM_W];
    assign pm10         = s_tdata[3*PM_W-1:2*PM_W];
    assign hcho         = s_tdata[4*PM_W-1:3*PM_W];
    assign sensor_ok    = s_tuser[0];
    assign hcho_present = s_tuser[1];

    assign s_tready  = (state_reg == IDLE) && !pend_reg;
    assign accept    = s_tvalid && s_tready;
    assign div_start = accept && sensor_ok && s_tlast;
    assign out_load  = pend_reg && (!m_tvalid || m_tready);

    always_comb
    begin
        smoky  = (pm25 > thr25_reg) && (pm10 > thr10_reg);
        if (!smoky)
            run_next = '0;
        else if (run_reg == {RUN_W{1'b1}})
            run_next = run_reg;
        else
            run_next = run_reg + 1'b1;

        acc_en     = (count_reg < CNT_W'(psam_pkg::MAX_SAMPLES));
        sum1_next  = acc_en ? sum1_reg + SUM_W'(pm1) : sum1_reg;
        sum25_next = acc_en ? sum25_reg + SUM_W'(pm25) : sum25_reg;
        sum10_next = acc_en ? sum10_reg + SUM_W'(pm10) : sum10_reg;
        count_next = acc_en ? count_reg + 1'b1 : count_reg;
        divisor    = (count_next == '0) ? CNT_W'(1) : count_next;

        alert_at    = {1'b0, warn_reg} + {1'b0, extra_reg};
        smoke_next  = smoke_reg;
        hcho_next   = hcho_reg;
        if ({1'b0, run_next} >= alert_at)
        begin
            smoke_next  = psam_pkg::STAT_ALERT;
            status_next = psam_pkg::STAT_ALERT;
        end
        else if (run_next >= warn_reg)
        begin
            smoke_next  = psam_pkg::STAT_WARNING;
            status_next = psam_pkg::STAT_WARNING;
        end
        else if (hcho_present && (hcho >= hlimit_reg))
        begin
            hcho_next   = 1'b1;
            status_next = psam_pkg::STAT_ALERT;
        end
        else
        begin
            smoke_next  = psam_pkg::STAT_OK;
            hcho_next   = 1'b0;
            status_next = psam_pkg::STAT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_reg   <= '0;
            extra_reg  <= '0;
            thr25_reg  <= '0;
            thr10_reg  <= '0;
            hlimit_reg <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                psam_pkg::REG_SMOKE_WARN:  warn_reg   <= cfg_data;
                psam_pkg::REG_SMOKE_EXTRA: extra_reg  <= cfg_data;
                psam_pkg::REG_PM25_THRESH: thr25_reg  <= cfg_data;
                psam_pkg::REG_PM10_THRESH: thr10_reg  <= cfg_data;
                psam_pkg::REG_HCHO_LIMIT:  hlimit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            run_reg    <= '0;
            sum1_reg   <= '0;
            sum25_reg  <= '0;
            sum10_reg  <= '0;
            count_reg  <= '0;
            avg1_reg   <= '0;
            avg25_reg  <= '0;
            avg10_reg  <= '0;
            smoke_reg  <= psam_pkg::STAT_OK;
            hcho_reg   <= 1'b0;
            status_reg <= psam_pkg::STAT_OK;
            upd_reg    <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            if (out_load)
                pend_reg <= 1'b0;
            unique case (state_reg)
                IDLE:
                begin
                    if (accept)
                    begin
                        if (!sensor_ok)
                        begin
                            status_reg <= psam_pkg::STAT_ERROR;
                            upd_reg    <= 1'b0;
                            pend_reg   <= 1'b1;
                        end
                        else
                        begin
                            run_reg    <= run_next;
                            smoke_reg  <= smoke_next;
                            hcho_reg   <= hcho_next;
                            status_reg <= status_next;
                            if (s_tlast)
                            begin
                                sum1_reg  <= '0;
                                sum25_reg <= '0;
                                sum10_reg <= '0;
                                count_reg <= '0;
                                upd_reg   <= 1'b1;
                                state_reg <= DIV;
                            end
                            else
                            begin
                                sum1_reg  <= sum1_next;
                                sum25_reg <= sum25_next;
                                sum10_reg <= sum10_next;
                                count_reg <= count_next;
                                upd_reg   <= 1'b0;
                                pend_reg  <= 1'b1;
                            end
                        end
                    end
                end
                DIV:
                begin
                    if (&div_done)
                    begin
                        avg1_reg  <= q1;
                        avg25_reg <= q25;
                        avg10_reg <= q10;
                        pend_reg  <= 1'b1;
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid <= 1'b0;
        else if (out_load)
            m_tvalid <= 1'b1;
        else if (m_tready)
            m_tvalid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata <= {{psam_pkg::OUT_PAD_W{1'b0}}, avg10_reg, avg25_reg, avg1_reg,
                        hcho_reg, smoke_reg, run_reg, status_reg};
            m_tuser <= upd_reg;
        end
    end

    psam_div u_div_pm1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum1_next),
        .divisor  (divisor),
        .done     (div_done[0]),
        .quotient (q1)
    );

    psam_div u_div_pm25 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum25_next),
        .divisor  (divisor),
        .done     (div_done[1]),
        .quotient (q25)
    );

    psam_div u_div_pm10 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum10_next),
        .divisor  (divisor),
        .done     (div_done[2]),
        .quotient (q10)
    );

endmodule
